@@ rtl/ems2hms_pkg.sv @@
// ----------------------------------------------------------------------------
// ems2hms_pkg
// Shared types and constants for the elapsed-time to ASCII timestamp core.
// ----------------------------------------------------------------------------
package ems2hms_pkg;

  localparam int unsigned MS_W     = 32;
  localparam int unsigned CHAR_W   = 7;
  localparam int unsigned DEC_BASE = 10;

  // reciprocal constants for division by a constant
  localparam logic [28:0] MUL_DIV1000 = 29'd274877907;  // >> 38
  localparam logic [21:0] MUL_DIV3600 = 22'd2386093;    // >> 33
  localparam logic [12:0] MUL_DIV10W  = 13'd6554;       // >> 16, x < 16384
  localparam logic [12:0] MUL_DIV60   = 13'd4370;       // >> 18, x < 4681
  localparam logic [7:0]  MUL_DIV10N  = 8'd205;         // >> 11, x < 1029

  localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
  localparam logic [5:0]  SEC_PER_MIN  = 6'd60;

  localparam logic [CHAR_W-1:0] CHAR_CR    = 7'h0D;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 7'h0A;
  localparam logic [CHAR_W-1:0] CHAR_COLON = 7'h3A;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;

  typedef struct packed {
    logic [3:0] hr_th;
    logic [3:0] hr_hu;
    logic [3:0] hr_te;
    logic [3:0] hr_un;
    logic [3:0] mn_te;
    logic [3:0] mn_un;
    logic [3:0] sc_te;
    logic [3:0] sc_un;
  } line_rec_t;

  typedef enum logic [3:0] {
    POS_IDLE,
    POS_CR,
    POS_LF,
    POS_HTH,
    POS_HHU,
    POS_HTE,
    POS_HUN,
    POS_C1,
    POS_MTE,
    POS_MUN,
    POS_C2,
    POS_STE,
    POS_SUN,
    POS_C3
  } char_pos_e;

  // split a value below 64 into tens and units
  function automatic logic [7:0] bcd_split(input logic [5:0] v);
    logic [3:0] tens;
    logic [5:0] units;
    tens = 4'd0;
    for (int i = 1; i <= 6; i++) begin
      if (v >= 6'(i * DEC_BASE)) begin
        tens = 4'(i);
      end
    end
    units = v - 6'(tens) * 6'(DEC_BASE);
    return {tens, units[3:0]};
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    return CHAR_ZERO | {3'b000, d};
  endfunction

endpackage

@@ rtl/ems2hms_if.sv @@
// ----------------------------------------------------------------------------
// ems2hms_if
// Valid/ready channels for elapsed time words in and ASCII characters out.
// ----------------------------------------------------------------------------
interface ems2hms_in_if;
  import ems2hms_pkg::*;

  logic            valid;
  logic            ready;
  logic [MS_W-1:0] elapsed_ms;

  modport source (output valid, output elapsed_ms, input ready);
  modport sink   (input valid, input elapsed_ms, output ready);
endinterface

interface ems2hms_out_if;
  import ems2hms_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

@@ rtl/ems2hms_front.sv @@
// ----------------------------------------------------------------------------
// ems2hms_front
// Five-stage conversion pipeline: milliseconds to hour, minute, second digits.
// ----------------------------------------------------------------------------
module ems2hms_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  ems2hms_in_if.sink             in_i,
  output ems2hms_pkg::line_rec_t rec_o,
  output logic                   push_valid_o,
  input  logic                   push_ready_i
);
  import ems2hms_pkg::*;

  logic [4:0]  v_q;
  logic        en;

  logic [60:0] prod1;
  logic [45:0] prod2;
  logic [23:0] prod3;
  logic [23:0] prod4;
  logic [14:0] prod5;
  logic [22:0] rest_full;
  logic [10:0] hd0_full;
  logic [11:0] sec_full;
  logic [6:0]  hd1_full;
  logic [7:0]  mn_bcd;
  logic [7:0]  sc_bcd;

  logic [22:0] s1_secs_q, s1_secs_d;
  logic [22:0] s2_secs_q;
  logic [10:0] s2_hours_q, s2_hours_d;
  logic [11:0] s3_rest_q, s3_rest_d;
  logic [6:0]  s3_hq1_q, s3_hq1_d;
  logic [10:0] s3_hours_q;
  logic [5:0]  s4_mins_q, s4_mins_d;
  logic [11:0] s4_rest_q;
  logic [3:0]  s4_hd0_q, s4_hd0_d;
  logic [3:0]  s4_hq2_q, s4_hq2_d;
  logic [6:0]  s4_hq1_q;
  logic [5:0]  s5_sec_q, s5_sec_d;
  logic [5:0]  s5_mins_q;
  logic [3:0]  s5_hd0_q;
  logic [3:0]  s5_hd1_q, s5_hd1_d;
  logic [3:0]  s5_hd2_q, s5_hd2_d;
  logic [3:0]  s5_hd3_q, s5_hd3_d;

  assign en           = !v_q[4] || push_ready_i;
  assign in_i.ready   = en;
  assign push_valid_o = v_q[4];

  always_comb begin
    prod1     = 61'(in_i.elapsed_ms) * 61'(MUL_DIV1000);
    s1_secs_d = prod1[60:38];

    prod2      = 46'(s1_secs_q) * 46'(MUL_DIV3600);
    s2_hours_d = prod2[43:33];

    rest_full = s2_secs_q - 23'(s2_hours_q) * 23'(SEC_PER_HOUR);
    s3_rest_d = rest_full[11:0];
    prod3     = 24'(s2_hours_q) * 24'(MUL_DIV10W);
    s3_hq1_d  = prod3[22:16];

    prod4     = 24'(s3_rest_q) * 24'(MUL_DIV60);
    s4_mins_d = prod4[23:18];
    hd0_full  = s3_hours_q - 11'(s3_hq1_q) * 11'(DEC_BASE);
    s4_hd0_d  = hd0_full[3:0];
    prod5     = 15'(s3_hq1_q) * 15'(MUL_DIV10N);
    s4_hq2_d  = prod5[14:11];

    sec_full = s4_rest_q - 12'(s4_mins_q) * 12'(SEC_PER_MIN);
    s5_sec_d = sec_full[5:0];
    hd1_full = s4_hq1_q - 7'(s4_hq2_q) * 7'(DEC_BASE);
    s5_hd1_d = hd1_full[3:0];
    if (s4_hq2_q >= 4'(DEC_BASE)) begin
      s5_hd3_d = 4'd1;
      s5_hd2_d = s4_hq2_q - 4'(DEC_BASE);
    end else begin
      s5_hd3_d = 4'd0;
      s5_hd2_d = s4_hq2_q;
    end

    mn_bcd      = bcd_split(s5_mins_q);
    sc_bcd      = bcd_split(s5_sec_q);
    rec_o.hr_th = s5_hd3_q;
    rec_o.hr_hu = s5_hd2_q;
    rec_o.hr_te = s5_hd1_q;
    rec_o.hr_un = s5_hd0_q;
    rec_o.mn_te = mn_bcd[7:4];
    rec_o.mn_un = mn_bcd[3:0];
    rec_o.sc_te = sc_bcd[7:4];
    rec_o.sc_un = sc_bcd[3:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[3:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_secs_q  <= s1_secs_d;
      s2_secs_q  <= s1_secs_q;
      s2_hours_q <= s2_hours_d;
      s3_rest_q  <= s3_rest_d;
      s3_hq1_q   <= s3_hq1_d;
      s3_hours_q <= s2_hours_q;
      s4_mins_q  <= s4_mins_d;
      s4_rest_q  <= s3_rest_q;
      s4_hd0_q   <= s4_hd0_d;
      s4_hq2_q   <= s4_hq2_d;
      s4_hq1_q   <= s3_hq1_q;
      s5_sec_q   <= s5_sec_d;
      s5_mins_q  <= s4_mins_q;
      s5_hd0_q   <= s4_hd0_q;
      s5_hd1_q   <= s5_hd1_d;
      s5_hd2_q   <= s5_hd2_d;
      s5_hd3_q   <= s5_hd3_d;
    end
  end

  a_digits_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[4] |-> (s5_hd0_q <= 4'd9) && (s5_hd1_q <= 4'd9) && (s5_hd2_q <= 4'd9)
               && (s5_hd3_q <= 4'd1) && (s5_mins_q < SEC_PER_MIN)
               && (s5_sec_q < SEC_PER_MIN))
    else $error("front: digit or field out of range");

endmodule

@@ rtl/ems2hms_fifo.sv @@
// ----------------------------------------------------------------------------
// ems2hms_fifo
// Small queue of converted line records between front and back.
// ----------------------------------------------------------------------------
module ems2hms_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  ems2hms_pkg::line_rec_t data_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output ems2hms_pkg::line_rec_t data_o,
  output logic                   valid_o
);
  import ems2hms_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  line_rec_t        mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d;
  logic [PTR_W-1:0] rd_q, rd_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d    = wr_q;
    rd_d    = rd_q;
    count_d = count_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("fifo: occupancy beyond depth");

  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !pop_i |=> full_o)
    else $error("fifo: full queue changed without a pop");

endmodule

@@ rtl/ems2hms_back.sv @@
// ----------------------------------------------------------------------------
// ems2hms_back
// Character sequencer: walks one line record out as ASCII, one char a cycle unless stalled.
// ----------------------------------------------------------------------------
module ems2hms_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ems2hms_pkg::line_rec_t rec_i,
  input  logic                   rec_valid_i,
  output logic                   pop_o,
  ems2hms_out_if.source          out_o
);
  import ems2hms_pkg::*;

  char_pos_e         state_q, state_d;
  line_rec_t         rec_q;
  logic              out_valid_q, out_valid_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic              last_q, last_d;
  logic              out_adv;

  assign out_adv         = !out_valid_q || out_o.ready;
  assign out_o.valid     = out_valid_q;
  assign out_o.char_code = char_q;
  assign out_o.last_char = last_q;

  always_comb begin
    state_d     = state_q;
    char_d      = char_q;
    last_d      = 1'b0;
    out_valid_d = out_adv ? 1'b0 : out_valid_q;
    pop_o       = rec_valid_i && ((state_q == POS_IDLE) || (out_adv && state_q == POS_C3));
    case (state_q)
      POS_IDLE: char_d = char_q;
      POS_CR:   char_d = CHAR_CR;
      POS_LF:   char_d = CHAR_LF;
      POS_HTH:  char_d = digit_char(rec_q.hr_th);
      POS_HHU:  char_d = digit_char(rec_q.hr_hu);
      POS_HTE:  char_d = digit_char(rec_q.hr_te);
      POS_HUN:  char_d = digit_char(rec_q.hr_un);
      POS_MTE:  char_d = digit_char(rec_q.mn_te);
      POS_MUN:  char_d = digit_char(rec_q.mn_un);
      POS_STE:  char_d = digit_char(rec_q.sc_te);
      POS_SUN:  char_d = digit_char(rec_q.sc_un);
      POS_C1, POS_C2, POS_C3: char_d = CHAR_COLON;
      default:  char_d = char_q;
    endcase
    if (state_q != POS_IDLE && out_adv) begin
      out_valid_d = 1'b1;
      last_d      = (state_q == POS_C3);
      case (state_q)
        POS_LF: begin
          if (rec_q.hr_th != 4'd0) begin
            state_d = POS_HTH;
          end else if (rec_q.hr_hu != 4'd0) begin
            state_d = POS_HHU;
          end else begin
            state_d = POS_HTE;
          end
        end
        POS_C3:  state_d = POS_IDLE;
        default: state_d = char_pos_e'(state_q + 4'd1);
      endcase
    end else if (!out_adv) begin
      char_d = char_q;
      last_d = last_q;
    end
    if (pop_o) begin
      state_d = POS_CR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= POS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
    if (pop_o) begin
      rec_q <= rec_i;
    end
  end

  a_last_is_colon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && last_q |-> char_q == CHAR_COLON)
    else $error("back: end of line flag on a character other than a colon");

  a_pop_starts_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> state_q == POS_CR)
    else $error("back: fetched record did not start a new line");

endmodule

@@ rtl/elapsed_ms_to_hhmmss_ascii_core.sv @@
// ----------------------------------------------------------------------------
// elapsed_ms_to_hhmmss_ascii_core
// Elapsed milliseconds to a CR LF hh:mm:ss: ASCII line, one character a word.
// ----------------------------------------------------------------------------
// in_i takes one 32-bit millisecond count per word (valid/ready). out_o gives
// the line back as 7-bit ASCII words: CR, LF, hours (two to four digits),
// colon, minutes, colon, seconds, colon; last_char marks the final colon.
// A line is 11 to 13 words. The back end sends one character a cycle from its
// output register while out_o is ready; the next line follows the final colon
// with no gap when a record is queued. An accepted word passes the five
// conversion stages, the queue, the record fetch and the output register
// before its first character. The queue holds FIFO_DEPTH converted lines, so
// in_i keeps accepting while out_o is stalled until the pipeline and queue
// are full; a stalled output word holds steady. Reset clears the pipeline,
// queue and sequencer at once.
// ----------------------------------------------------------------------------
module elapsed_ms_to_hhmmss_ascii_core #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ems2hms_in_if.sink    in_i,
  ems2hms_out_if.source out_o
);
  import ems2hms_pkg::*;

  line_rec_t front_rec;
  line_rec_t fifo_rec;
  logic      push_valid;
  logic      fifo_full;
  logic      fifo_valid;
  logic      pop;

  ems2hms_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .rec_o        (front_rec),
    .push_valid_o (push_valid),
    .push_ready_i (!fifo_full)
  );

  ems2hms_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_valid),
    .data_i  (front_rec),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .data_o  (fifo_rec),
    .valid_o (fifo_valid)
  );

  ems2hms_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_i       (fifo_rec),
    .rec_valid_i (fifo_valid),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule

@@ sim/elapsed_ms_to_hhmmss_ascii_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elapsed_ms_to_hhmmss_ascii_core_tb
// Self-checking bench for the millisecond to ASCII timestamp line core.
// ----------------------------------------------------------------------------
// A table of directed counts (boundaries of seconds, minutes, hours, the
// hour-width changes and the full-scale value) runs first, then random counts
// weighted towards those boundaries. Each accepted word is turned into its
// expected line of characters; every character out is checked in order.
// Both channels idle and stall at random throughout.
// ----------------------------------------------------------------------------
module elapsed_ms_to_hhmmss_ascii_core_tb;
  import ems2hms_pkg::*;

  localparam int unsigned RAND_WORDS   = 280;
  localparam int unsigned MAX_REPORTED = 10;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } ts_char_t;

  typedef struct {
    logic [MS_W-1:0] ms;
    string           shown;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ems2hms_in_if  in_bus ();
  ems2hms_out_if out_bus ();

  elapsed_ms_to_hhmmss_ascii_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  ts_char_t    expected_chars_q[$];
  ts_char_t    want;
  int unsigned mismatches    = 0;
  int unsigned chars_checked = 0;
  int unsigned lines_sent    = 0;
  int unsigned hour_width_cnt[2:4] = '{0, 0, 0};

  // visible part only: cr and lf lead every line
  dir_row_t dir_rows[18] = '{
    '{32'd0,             "00:00:00:"},
    '{32'd1,             ""},
    '{32'd999,           "00:00:00:"},
    '{32'd1000,          "00:00:01:"},
    '{32'd59_999,        "00:00:59:"},
    '{32'd60_000,        "00:01:00:"},
    '{32'd3_599_999,     "00:59:59:"},
    '{32'd3_600_000,     "01:00:00:"},
    '{32'd35_999_999,    ""},
    '{32'd36_000_000,    "10:00:00:"},
    '{32'd359_999_999,   "99:59:59:"},
    '{32'd360_000_000,   "100:00:00:"},
    '{32'd3_599_999_999, "999:59:59:"},
    '{32'd3_600_000_000, "1000:00:00:"},
    '{32'h8000_0000,     ""},
    '{32'h5555_5555,     ""},
    '{32'hAAAA_AAAA,     ""},
    '{32'hFFFF_FFFF,     "1193:02:47:"}
  };

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic void push_char(input logic [CHAR_W-1:0] code, input logic last);
    expected_chars_q.push_back('{code: code, last: last});
  endfunction

  function automatic void predict_line(input logic [MS_W-1:0] ms);
    logic [MS_W-1:0] secs;
    logic [10:0]     hrs;
    logic [11:0]     rest;
    logic [5:0]      mins;
    logic [5:0]      sc;
    secs = ms / 32'd1000;
    hrs  = 11'(secs / 32'd3600);
    rest = 12'(secs % 32'd3600);
    mins = 6'(rest / 12'd60);
    sc   = 6'(rest % 12'd60);
    push_char(CHAR_CR, 1'b0);
    push_char(CHAR_LF, 1'b0);
    if (hrs >= 11'd1000) begin
      push_char(CHAR_ZERO + 7'((hrs / 11'd1000) % 11'd10), 1'b0);
    end
    if (hrs >= 11'd100) begin
      push_char(CHAR_ZERO + 7'((hrs / 11'd100) % 11'd10), 1'b0);
    end
    push_char(CHAR_ZERO + 7'((hrs / 11'd10) % 11'd10), 1'b0);
    push_char(CHAR_ZERO + 7'(hrs % 11'd10), 1'b0);
    push_char(CHAR_COLON, 1'b0);
    push_char(CHAR_ZERO + 7'(mins / 6'd10), 1'b0);
    push_char(CHAR_ZERO + 7'(mins % 6'd10), 1'b0);
    push_char(CHAR_COLON, 1'b0);
    push_char(CHAR_ZERO + 7'(sc / 6'd10), 1'b0);
    push_char(CHAR_ZERO + 7'(sc % 6'd10), 1'b0);
    push_char(CHAR_COLON, 1'b1);
    hour_width_cnt[(hrs >= 11'd1000) ? 4 : (hrs >= 11'd100) ? 3 : 2]++;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  // counts weighted towards the carries between seconds, minutes and hours
  function automatic logic [MS_W-1:0] random_elapsed();
    int unsigned k;
    logic        hi;
    hi = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom();
      3:       return $urandom_range(0, 3_599_999);
      4:       return $urandom_range(0, 59_999);
      5:       return $urandom_range(0, 4_294_966) * 32'd1000 + (hi ? 32'd999 : 32'd0);
      6: begin
        k = $urandom_range(0, 1193);
        return k * 32'd3_600_000 - ((hi && k != 0) ? 32'd1 : 32'd0);
      end
      7: begin
        k = $urandom_range(0, 5000);
        if (hi) return 32'd3_600_000_000 - 32'd2500 + k;
        return 32'd360_000_000 - 32'd2500 + k;
      end
      8:       return $urandom_range(0, 71_581) * 32'd60_000 + (hi ? 32'd59_999 : 32'd0);
      default: return $urandom_range(32'hFFF0_0000, 32'hFFFF_FFFF);
    endcase
  endfunction

  task automatic send_elapsed(input logic [MS_W-1:0] ms, input string shown);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid      <= 1'b1;
    in_bus.elapsed_ms <= ms;
    do @(posedge clk_i); while (!in_bus.ready);
    lines_sent++;
    if (shown.len() == 0) begin
      predict_line(ms);
    end else begin
      push_char(CHAR_CR, 1'b0);
      push_char(CHAR_LF, 1'b0);
      for (int k = 0; k < shown.len(); k++) begin
        push_char(7'(shown[k]), k == shown.len() - 1);
      end
      hour_width_cnt[shown.len() - 7]++;
    end
    @(negedge clk_i);
  endtask

  task automatic drain_lines();
    in_bus.valid <= 1'b0;
    wait (expected_chars_q.size() == 0);
    @(negedge clk_i);
  endtask

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTED) begin
      $display("[%0t] %s", $realtime, msg);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (expected_chars_q.size() == 0) begin
        note_failure($sformatf("unexpected word: code=%h last=%b",
                               out_bus.char_code, out_bus.last_char));
      end else begin
        want = expected_chars_q.pop_front();
        if (out_bus.char_code !== want.code || out_bus.last_char !== want.last) begin
          note_failure($sformatf("char %0d: expected code=%h last=%b, got code=%h last=%b",
                                 chars_checked, want.code, want.last,
                                 out_bus.char_code, out_bus.last_char));
        end
        chars_checked++;
      end
    end
  end

  initial begin
    int unsigned stall;
    out_bus.ready = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      out_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(negedge clk_i);
      stall = pick_gap();
      if (stall != 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
    end
  end

  initial begin
    in_bus.valid      = 1'b0;
    in_bus.elapsed_ms = '0;
    wait (rst_ni);
    @(negedge clk_i);
    foreach (dir_rows[i]) begin
      send_elapsed(dir_rows[i].ms, dir_rows[i].shown);
    end
    drain_lines();
    for (int unsigned i = 0; i < RAND_WORDS; i++) begin
      if (i == RAND_WORDS / 2) begin
        drain_lines();
      end
      send_elapsed(random_elapsed(), "");
    end
    in_bus.valid <= 1'b0;
    wait (expected_chars_q.size() == 0);
    repeat (40) @(posedge clk_i);
    $display("%0d timestamp words sent (%0d from the table), %0d characters checked",
             lines_sent, $size(dir_rows), chars_checked);
    $display("lines with 2/3/4 hour digits: %0d/%0d/%0d, mismatches: %0d",
             hour_width_cnt[2], hour_width_cnt[3], hour_width_cnt[4], mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
